>>> sv/isbf_pkg.sv
// Shared constants, codes and transaction types for the IPv4 source blocklist filter.
package isbf_pkg;

  // Blocked-address set capacity and derived widths
  localparam int TABLE_ENTRIES = 1024;
  localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Frame layout
  localparam logic [15:0] IPV4_ETHER_TYPE = 16'h0800;
  localparam logic [5:0]  MIN_FRAME_BYTES = 6'd34;
  localparam logic [5:0]  ETYPE_FIRST     = 6'd12;
  localparam logic [5:0]  ETYPE_LAST      = 6'd13;
  localparam logic [5:0]  SRC_FIRST       = 6'd26;
  localparam logic [5:0]  SRC_LAST        = 6'd29;

  // Input operation codes
  localparam logic [1:0] OP_FRAME_BYTE = 2'd0;
  localparam logic [1:0] OP_ADD        = 2'd1;
  localparam logic [1:0] OP_REMOVE     = 2'd2;

  // Result codes
  localparam logic       KIND_VERDICT = 1'b0;
  localparam logic       KIND_TABLE   = 1'b1;
  localparam logic       VERDICT_PASS = 1'b0;
  localparam logic       VERDICT_DROP = 1'b1;
  localparam logic [1:0] TS_DONE      = 2'd0;
  localparam logic [1:0] TS_FULL      = 2'd1;
  localparam logic [1:0] TS_ABSENT    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [31:0] table_address;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        verdict;
    logic [1:0]  table_status;
    logic [63:0] dropped_count;
    logic [63:0] passed_count;
  } out_item_t;

endpackage

>>> sv/ipv4_source_blocklist_filter.sv
// IPv4 source blocklist filter: header capture, key memory scan, set update and counters.
//
// Input channel (in_valid / in_stall / in_data) carries one transaction per frame byte,
// or one add / remove of a blocked address. Result channel (out_valid / out_stall /
// out_data) carries one verdict per frame end and one status per add or remove.
// Blocked addresses live densely packed in one single-port key memory with a fill
// count; a remove moves the last entry into the freed slot.
// Flow of each accepted transaction:
//   - a frame byte that is not the last one gives no result;
//   - a short or non-IPv4 frame end loads the output register from the done state;
//   - a lookup frame end, an add or a remove scans the filled entries one per cycle
//     through the key memory port and stops at the first hit or at the fill count;
//     a remove that moves the last entry then passes the move-read and move-write
//     states before the result loads. The input stalls until the load, so the next
//     transaction is taken in the cycle after it.
// Operation code 3 is consumed with no effect.
// Reset (rst_n low, synchronous) empties the set by clearing the fill count, zeroes
// the counters and the frame capture, and drops any pending result; no clearing pass.
// While the receiver stalls, the result register holds; frame bytes that give no
// result keep flowing, and a finished lookup waits until the register frees.
module ipv4_source_blocklist_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  isbf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output isbf_pkg::out_item_t  out_data
);
  import isbf_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_MOVE_RD = 3'd2;
  localparam logic [2:0] S_MOVE_WR = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [5:0]        off_r, off_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic [31:0]       src_r, src_nxt;
  logic [63:0]       drop_r, drop_nxt;
  logic [63:0]       pass_r, pass_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              kind_r, kind_nxt;
  logic              verdict_r, verdict_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_load;

  // Key memory
  logic [31:0]       keys_mem [TABLE_ENTRIES];
  logic [31:0]       mem_q_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [31:0]       wr_data;

  // Header capture with the incoming byte
  logic [5:0]        off_upd;
  logic [15:0]       etype_upd;
  logic [31:0]       src_upd;
  logic              is_ipv4;
  logic [CNT_W-1:0]  count_m1;
  logic [ADDR_W-1:0] last_addr;
  logic              hit, scan_end;

  assign off_upd   = (off_r < MIN_FRAME_BYTES) ? off_r + 6'd1 : off_r;
  assign etype_upd = (off_r == ETYPE_FIRST || off_r == ETYPE_LAST)
                     ? {etype_r[7:0], in_data.frame_byte} : etype_r;
  assign src_upd   = (off_r >= SRC_FIRST && off_r <= SRC_LAST)
                     ? {src_r[23:0], in_data.frame_byte} : src_r;
  assign is_ipv4   = (off_upd >= MIN_FRAME_BYTES) && (etype_upd == IPV4_ETHER_TYPE);

  assign count_m1  = count_r - 1'b1;
  assign last_addr = count_m1[ADDR_W-1:0];
  assign hit       = pend_r && (mem_q_r == key_r);
  assign scan_end  = hit || (!pend_r && idx_r == count_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequence capture, scan, set update and result
  always_comb begin
    state_nxt   = state_r;
    off_nxt     = off_r;
    etype_nxt   = etype_r;
    src_nxt     = src_r;
    drop_nxt    = drop_r;
    pass_nxt    = pass_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    cmp_idx_nxt = cmp_idx_r;
    slot_nxt    = slot_r;
    key_nxt     = key_r;
    op_nxt      = op_r;
    kind_nxt    = kind_r;
    verdict_nxt = verdict_r;
    status_nxt  = status_r;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_r[ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_r[ADDR_W-1:0];
    wr_data     = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.operation)
            OP_FRAME_BYTE: begin
              off_nxt   = off_upd;
              etype_nxt = etype_upd;
              src_nxt   = src_upd;
              if (in_data.frame_end) begin
                off_nxt   = '0;
                etype_nxt = '0;
                src_nxt   = '0;
                if (is_ipv4) begin
                  key_nxt   = src_upd;
                  op_nxt    = OP_FRAME_BYTE;
                  idx_nxt   = '0;
                  pend_nxt  = 1'b0;
                  state_nxt = S_SCAN;
                end else begin
                  kind_nxt    = KIND_VERDICT;
                  verdict_nxt = VERDICT_PASS;
                  status_nxt  = TS_DONE;
                  state_nxt   = S_DONE;
                end
              end
            end
            OP_ADD, OP_REMOVE: begin
              key_nxt   = in_data.table_address;
              op_nxt    = in_data.operation;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          pend_nxt = 1'b0;
          priority if (op_r == OP_ADD) begin
            kind_nxt    = KIND_TABLE;
            verdict_nxt = VERDICT_PASS;
            state_nxt   = S_DONE;
            if (hit) begin
              status_nxt = TS_DONE;
            end else if (count_r == CNT_W'(TABLE_ENTRIES)) begin
              status_nxt = TS_FULL;
            end else begin
              // append at the fill count
              wr_en      = 1'b1;
              wr_addr    = count_r[ADDR_W-1:0];
              wr_data    = key_r;
              count_nxt  = count_r + 1'b1;
              status_nxt = TS_DONE;
            end
          end else if (op_r == OP_REMOVE) begin
            kind_nxt    = KIND_TABLE;
            verdict_nxt = VERDICT_PASS;
            if (!hit) begin
              status_nxt = TS_ABSENT;
              state_nxt  = S_DONE;
            end else if (cmp_idx_r == last_addr) begin
              count_nxt  = count_m1;
              status_nxt = TS_DONE;
              state_nxt  = S_DONE;
            end else begin
              slot_nxt  = cmp_idx_r;
              state_nxt = S_MOVE_RD;
            end
          end else begin
            kind_nxt   = KIND_VERDICT;
            status_nxt = TS_DONE;
            state_nxt  = S_DONE;
            if (hit) begin
              drop_nxt    = drop_r + 64'd1;
              verdict_nxt = VERDICT_DROP;
            end else begin
              pass_nxt    = pass_r + 64'd1;
              verdict_nxt = VERDICT_PASS;
            end
          end
        end else if (idx_r < count_r) begin
          // issue the next entry; compare it in the next cycle
          rd_en       = 1'b1;
          rd_addr     = idx_r[ADDR_W-1:0];
          cmp_idx_nxt = idx_r[ADDR_W-1:0];
          idx_nxt     = idx_r + 1'b1;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_MOVE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = last_addr;
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // move the last entry into the freed slot
        wr_en      = 1'b1;
        wr_addr    = slot_r;
        wr_data    = mem_q_r;
        count_nxt  = count_m1;
        status_nxt = TS_DONE;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load or drain the result register
  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.result_kind   = kind_r;
      out_data_nxt.verdict       = verdict_r;
      out_data_nxt.table_status  = status_r;
      out_data_nxt.dropped_count = drop_r;
      out_data_nxt.passed_count  = pass_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Key memory: one access per cycle, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= keys_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      off_r       <= '0;
      etype_r     <= '0;
      src_r       <= '0;
      drop_r      <= '0;
      pass_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      etype_r     <= etype_nxt;
      src_r       <= src_nxt;
      drop_r      <= drop_nxt;
      pass_r      <= pass_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    slot_r     <= slot_nxt;
    key_r      <= key_nxt;
    op_r       <= op_nxt;
    kind_r     <= kind_nxt;
    verdict_r  <= verdict_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Fill count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count above capacity");

  // Reads stay inside the filled region
  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_addr) < count_r))
    else $error("key memory read beyond fill count");

  // Single memory port: no read and write together
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("key memory read and write in one cycle");

  // Fill count moves by at most one per transaction
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r + 1'b1 == $past(count_r)))
    else $error("fill count jumped");

endmodule

>>> tb/ipv4_source_blocklist_filter_tb.sv
// Self-checking testbench for the IPv4 source blocklist filter: directed and random traffic.
`timescale 1ns / 100ps

module ipv4_source_blocklist_filter_tb;
  import isbf_pkg::*;

  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [15:0] IPV6_ETHER_TYPE = 16'h86DD;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int          RANDOM_ITEMS    = 1100;
  localparam int          IDLE_PCT        = 12;
  localparam int          POOL_SIZE       = 16;
  localparam int          PRINT_CAP       = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow of the filter: blocked set, header capture and counters
  bit          blocked_set[logic [31:0]];
  logic [5:0]  seen_bytes  = '0;
  logic [15:0] held_etype  = '0;
  logic [31:0] held_source = '0;
  logic [63:0] drop_total  = '0;
  logic [63:0] pass_total  = '0;
  out_item_t   awaited_outcomes[$];

  logic [31:0] addr_pool[POOL_SIZE];
  bit          calm        = 1'b0;
  int unsigned cycle_count = 0;
  int          mismatches  = 0;
  int          items_sent  = 0;

  always #4 clk = ~clk;

  ipv4_source_blocklist_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_outcomes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result channel at random outside calm stretches
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted result with the oldest outstanding expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(out_data.result_kind), '0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_data.result_kind !== want.result_kind)
          report_mismatch("result_kind", 64'(out_data.result_kind), 64'(want.result_kind));
        if (out_data.verdict !== want.verdict)
          report_mismatch("verdict", 64'(out_data.verdict), 64'(want.verdict));
        if (out_data.table_status !== want.table_status)
          report_mismatch("table_status", 64'(out_data.table_status),
                          64'(want.table_status));
        if (out_data.dropped_count !== want.dropped_count)
          report_mismatch("dropped_count", out_data.dropped_count, want.dropped_count);
        if (out_data.passed_count !== want.passed_count)
          report_mismatch("passed_count", out_data.passed_count, want.passed_count);
      end
    end
  end

  // Advance the shadow state by one accepted transaction and queue its outcome
  function automatic void filter_predict(in_item_t it);
    out_item_t res;
    bit        gives;
    res   = '0;
    gives = 1'b0;
    case (it.operation)
      OP_FRAME_BYTE: begin
        if (seen_bytes == ETYPE_FIRST || seen_bytes == ETYPE_LAST)
          held_etype = {held_etype[7:0], it.frame_byte};
        else if (seen_bytes >= SRC_FIRST && seen_bytes <= SRC_LAST)
          held_source = {held_source[23:0], it.frame_byte};
        if (seen_bytes < MIN_FRAME_BYTES)
          seen_bytes++;
        if (it.frame_end) begin
          gives            = 1'b1;
          res.result_kind  = KIND_VERDICT;
          res.verdict      = VERDICT_PASS;
          res.table_status = TS_DONE;
          if (seen_bytes >= MIN_FRAME_BYTES && held_etype == IPV4_ETHER_TYPE) begin
            if (blocked_set.exists(held_source)) begin
              drop_total++;
              res.verdict = VERDICT_DROP;
            end else begin
              pass_total++;
            end
          end
          seen_bytes  = '0;
          held_etype  = '0;
          held_source = '0;
        end
      end
      OP_ADD: begin
        gives           = 1'b1;
        res.result_kind = KIND_TABLE;
        if (blocked_set.exists(it.table_address)) begin
          res.table_status = TS_DONE;
        end else if (blocked_set.num() >= TABLE_ENTRIES) begin
          res.table_status = TS_FULL;
        end else begin
          blocked_set[it.table_address] = 1'b1;
          res.table_status = TS_DONE;
        end
      end
      OP_REMOVE: begin
        gives           = 1'b1;
        res.result_kind = KIND_TABLE;
        if (blocked_set.exists(it.table_address)) begin
          blocked_set.delete(it.table_address);
          res.table_status = TS_DONE;
        end else begin
          res.table_status = TS_ABSENT;
        end
      end
      default: begin
        // unused code: no effect
      end
    endcase
    if (gives) begin
      res.dropped_count = drop_total;
      res.passed_count  = pass_total;
      awaited_outcomes.push_back(res);
    end
  endfunction

  // Present one transaction at the falling edge and hold it until accepted
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_predict(it);
    if (it.operation != OP_UNUSED)
      items_sent++;
  endtask

  task automatic send_table_op(logic [1:0] op, logic [31:0] addr);
    in_item_t it;
    it.operation     = op;
    it.frame_byte    = 8'($urandom);
    it.frame_end     = 1'($urandom);
    it.table_address = addr;
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it.operation     = OP_UNUSED;
    it.frame_byte    = 8'($urandom);
    it.frame_end     = 1'($urandom);
    it.table_address = $urandom;
    send_item(it);
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(99) < 85)
      return addr_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Send bytes [from, upto) of a frame of len bytes; header fields land at their offsets
  task automatic send_frame_part(logic [15:0] etype, logic [31:0] src, int len,
                                 int from, int upto, bit mixed);
    in_item_t it;
    for (int p = from; p < upto; p++) begin
      if (mixed && $urandom_range(99) < 5) begin
        case ($urandom_range(2))
          0:       send_noise();
          1:       send_table_op(OP_ADD, pick_addr());
          default: send_table_op(OP_REMOVE, pick_addr());
        endcase
      end
      it.operation     = OP_FRAME_BYTE;
      it.frame_byte    = 8'($urandom);
      it.frame_end     = (p == len - 1);
      it.table_address = $urandom;
      if (p == int'(ETYPE_FIRST))
        it.frame_byte = etype[15:8];
      else if (p == int'(ETYPE_LAST))
        it.frame_byte = etype[7:0];
      else if (p >= int'(SRC_FIRST) && p <= int'(SRC_LAST))
        it.frame_byte = src[8 * (int'(SRC_LAST) - p) +: 8];
      send_item(it);
    end
  endtask

  task automatic test_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Header rules: length, EtherType, hits, misses, duplicate add and missing remove
  task automatic test_header_rules();
    logic [31:0] host;
    host = 32'h0A00_0001;
    send_frame_part(IPV4_ETHER_TYPE, host, 1, 0, 1, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, host, 34, 0, 34, 1'b0);
    send_table_op(OP_REMOVE, host);
    send_table_op(OP_ADD, host);
    send_table_op(OP_ADD, host);
    send_frame_part(IPV4_ETHER_TYPE, host, 34, 0, 34, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, host, 70, 0, 70, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, host, 33, 0, 33, 1'b0);
    send_frame_part(IPV6_ETHER_TYPE, host, 40, 0, 40, 1'b0);
    send_table_op(OP_REMOVE, host);
    send_table_op(OP_REMOVE, host);
    send_noise();
  endtask

  // Extreme addresses in the set and in the header
  task automatic test_address_extremes();
    send_table_op(OP_ADD, 32'h0000_0000);
    send_table_op(OP_ADD, 32'hFFFF_FFFF);
    send_frame_part(IPV4_ETHER_TYPE, 32'h0000_0000, 34, 0, 34, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, 32'hFFFF_FFFF, 34, 0, 34, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, 32'hFFFF_FFFE, 34, 0, 34, 1'b0);
    send_table_op(OP_REMOVE, 32'h0000_0000);
    send_table_op(OP_REMOVE, 32'hFFFF_FFFF);
  endtask

  // Table updates and unused codes between bytes must not disturb the capture
  task automatic test_ops_inside_frame();
    logic [31:0] host;
    host = 32'hC633_6407;
    send_frame_part(IPV4_ETHER_TYPE, host, 36, 0, 27, 1'b0);
    send_table_op(OP_ADD, host);
    send_noise();
    send_frame_part(IPV4_ETHER_TYPE, host, 36, 27, 36, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, host, 34, 0, 13, 1'b0);
    send_table_op(OP_REMOVE, host);
    send_frame_part(IPV4_ETHER_TYPE, host, 34, 13, 34, 1'b0);
  endtask

  // Random mix of well-formed frames, table updates, broken frames and noise over a small address pool
  task automatic test_random_traffic();
    int          first;
    int          roll;
    int          len;
    logic [15:0] etype;
    first = items_sent;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < POOL_SIZE; k++)
      addr_pool[k] = $urandom;
    while (items_sent < first + RANDOM_ITEMS) begin
      // hold a stretch with no idling on either side
      calm = (items_sent - first >= 400) && (items_sent - first < 650);
      roll = $urandom_range(99);
      if (roll < 45) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(41, 70) : $urandom_range(34, 40);
        send_frame_part(IPV4_ETHER_TYPE, pick_addr(), len, 0, len, 1'b1);
      end else if (roll < 60) begin
        len = $urandom_range(1, 33);
        send_frame_part(IPV4_ETHER_TYPE, pick_addr(), len, 0, len, 1'b1);
      end else if (roll < 70) begin
        etype = $urandom_range(1) ? (IPV4_ETHER_TYPE ^ (16'h1 << $urandom_range(15)))
                                  : 16'($urandom);
        if (etype == IPV4_ETHER_TYPE)
          etype = etype ^ 16'h1;
        len = $urandom_range(14, 40);
        send_frame_part(etype, pick_addr(), len, 0, len, 1'b1);
      end else if (roll < 95) begin
        send_table_op($urandom_range(1) ? OP_ADD : OP_REMOVE, pick_addr());
      end else begin
        send_noise();
      end
    end
    calm = 1'b0;
  endtask

  // Fill every slot, then probe the full set
  task automatic test_table_full();
    logic [31:0] cand;
    logic [31:0] spare;
    logic [31:0] member;
    cand = 32'hC0A8_0000;
    while (blocked_set.num() < TABLE_ENTRIES) begin
      if (!blocked_set.exists(cand))
        send_table_op(OP_ADD, cand);
      cand++;
    end
    spare = cand;
    while (blocked_set.exists(spare))
      spare++;
    void'(blocked_set.first(member));
    send_table_op(OP_ADD, spare);
    send_table_op(OP_ADD, member);
    send_frame_part(IPV4_ETHER_TYPE, member, 34, 0, 34, 1'b0);
    send_frame_part(IPV4_ETHER_TYPE, spare, 34, 0, 34, 1'b0);
    send_table_op(OP_REMOVE, member);
    send_table_op(OP_ADD, spare);
    send_table_op(OP_ADD, member);
    send_table_op(OP_REMOVE, member);
    send_frame_part(IPV4_ETHER_TYPE, spare, 34, 0, 34, 1'b0);
  endtask

  initial begin
    test_reset();
    test_header_rules();
    test_address_extremes();
    test_ops_inside_frame();
    test_random_traffic();
    test_table_full();
    @(negedge clk);
    in_valid <= 1'b0;
    // drain outstanding results, then watch for strays
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
